// ===== hw/rtl/bli_pkg.sv =====
`default_nettype none
package bli_pkg;

    localparam int BAR_LEDS   = 3;
    localparam int SECTIONS   = 5;
    localparam int NUM_BOUNDS = SECTIONS - 1;
    localparam int LAMP_W     = BAR_LEDS + 1;
    localparam int SEC_W      = 3;
    localparam int CHASE_W    = 3;
    localparam int PCT_W      = 7;
    localparam int MARGIN_W   = 4;
    localparam int DLY_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [DLY_W-1:0] HOLD_OFF_MS = 11'd200;
    localparam logic [DLY_W-1:0] BLINK_ON_MS = 11'd50;
    localparam logic [DLY_W-1:0] HALF_SEC_MS = 11'd500;
    localparam logic [DLY_W-1:0] ONE_SEC_MS  = 11'd1000;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = CFG_IDX_W'(NUM_BOUNDS);

    localparam logic [NUM_BOUNDS-1:0][PCT_W-1:0] BOUND_RESET = {7'd75, 7'd50, 7'd25, 7'd5};
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd3;

    typedef enum logic [3:0] {
        PH_SHOW     = 4'b0001,
        PH_LOWBLINK = 4'b0010,
        PH_CHGSTART = 4'b0100,
        PH_CHGNEXT  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [NUM_BOUNDS-1:0][PCT_W-1:0] bound;
        logic [MARGIN_W-1:0]              margin;
    } t_cfg;

    typedef struct packed {
        logic [SEC_W-1:0]    level_section;
        logic [BAR_LEDS-1:0] bar_mask;
        logic                red_on;
    } t_result;

    // bound k sits between sections k-1 and k; fixed ends at 0 and full
    function automatic logic [PCT_W-1:0] bound_of(t_cfg cfg, logic [SEC_W:0] k);
        logic [PCT_W-1:0] r;
        r = PCT_FULL;
        if (k == '0) begin
            r = '0;
        end
        for (int j = 0; j < NUM_BOUNDS; j++) begin
            if (k == (SEC_W+1)'(j + 1)) begin
                r = cfg.bound[j];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bli_core.sv =====
`default_nettype none
module bli_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire                          i_cmd,
    input  wire [bli_pkg::PCT_W-1:0]     i_pct,
    input  wire                          i_chg,
    input  wire                          i_cut,
    input  bli_pkg::t_cfg                i_cfg,
    output bli_pkg::t_result             o_res
);

    localparam logic [bli_pkg::SEC_W-1:0] TOP_SEC = bli_pkg::SEC_W'(bli_pkg::SECTIONS - 1);

    logic [bli_pkg::SEC_W-1:0]   r_section, n_section;
    logic                        r_known, n_known;
    bli_pkg::t_phase             r_phase, n_phase;
    logic [bli_pkg::DLY_W-1:0]   r_delay, n_delay;
    logic [bli_pkg::CHASE_W-1:0] r_chase, n_chase;
    logic [bli_pkg::LAMP_W-1:0]  r_lamp, n_lamp;

    logic [bli_pkg::SEC_W-1:0]   w_pick;
    logic                        w_found;
    logic [bli_pkg::PCT_W-1:0]   w_lo, w_hi, w_blo, w_bhi;
    logic [bli_pkg::PCT_W:0]     w_pct_m, w_hi_m;
    logic                        w_down, w_up;
    logic [bli_pkg::SEC_W-1:0]   w_disp;
    logic [bli_pkg::SEC_W:0]     w_cnt;
    logic [bli_pkg::LAMP_W-1:0]  w_show_lamp;
    bli_pkg::t_phase             w_show_phase;
    logic [bli_pkg::DLY_W-1:0]   w_show_delay;
    logic [bli_pkg::CHASE_W-1:0] w_show_chase;
    logic [bli_pkg::DLY_W-1:0]   w_dec;
    logic [bli_pkg::CHASE_W:0]   w_next_id;
    logic                        w_run_show;

    // section choice
    always_comb begin
        w_pick  = TOP_SEC;
        w_found = 1'b0;
        w_blo   = '0;
        w_bhi   = '0;
        if (!r_known) begin
            for (int s = 0; s < bli_pkg::SECTIONS; s++) begin
                w_blo = bli_pkg::bound_of(i_cfg, (bli_pkg::SEC_W+1)'(s));
                w_bhi = bli_pkg::bound_of(i_cfg, (bli_pkg::SEC_W+1)'(s + 1));
                if (!w_found && w_blo <= i_pct && i_pct < w_bhi) begin
                    w_pick  = bli_pkg::SEC_W'(s);
                    w_found = 1'b1;
                end
            end
        end
        w_lo    = bli_pkg::bound_of(i_cfg, {1'b0, r_section});
        w_hi    = bli_pkg::bound_of(i_cfg, {1'b0, r_section} + (bli_pkg::SEC_W+1)'(1));
        w_pct_m = {1'b0, i_pct} + (bli_pkg::PCT_W+1)'(i_cfg.margin);
        w_hi_m  = {1'b0, w_hi} + (bli_pkg::PCT_W+1)'(i_cfg.margin);
        w_down  = (r_section != '0) &&
                  (i_chg ? (w_pct_m < {1'b0, w_lo}) : (i_pct < w_lo));
        w_up    = (r_section != TOP_SEC) &&
                  (i_chg ? (i_pct >= w_hi) : ({1'b0, i_pct} >= w_hi_m));
        if (r_known) begin
            if (w_down) begin
                w_pick = r_section - bli_pkg::SEC_W'(1);
            end else if (w_up) begin
                w_pick = r_section + bli_pkg::SEC_W'(1);
            end else begin
                w_pick = r_section;
            end
        end
    end

    // display pass
    always_comb begin
        w_disp       = i_cut ? '0 : w_pick;
        w_cnt        = '0;
        w_show_lamp  = '0;
        w_show_chase = r_chase;
        if (!i_chg) begin
            w_show_phase = bli_pkg::PH_SHOW;
            w_show_delay = bli_pkg::ONE_SEC_MS;
            if (w_disp == '0) begin
                w_show_phase = bli_pkg::PH_LOWBLINK;
                w_show_delay = bli_pkg::HOLD_OFF_MS;
            end else if (w_disp == bli_pkg::SEC_W'(1)) begin
                w_show_lamp[0] = 1'b1;
            end else begin
                w_cnt = {1'b0, w_disp} - (bli_pkg::SEC_W+1)'(1);
                if (w_cnt > (bli_pkg::SEC_W+1)'(bli_pkg::BAR_LEDS)) begin
                    w_cnt = (bli_pkg::SEC_W+1)'(bli_pkg::BAR_LEDS);
                end
            end
        end else begin
            w_show_phase = bli_pkg::PH_CHGSTART;
            w_show_delay = bli_pkg::HALF_SEC_MS;
            if (w_disp > bli_pkg::SEC_W'(1)) begin
                w_cnt = {1'b0, w_disp} - (bli_pkg::SEC_W+1)'(1);
                if (w_cnt > (bli_pkg::SEC_W+1)'(bli_pkg::BAR_LEDS - 1)) begin
                    w_cnt = (bli_pkg::SEC_W+1)'(bli_pkg::BAR_LEDS - 1);
                end
            end
            w_show_chase = bli_pkg::CHASE_W'(w_cnt + (bli_pkg::SEC_W+1)'(1));
        end
        for (int i = 1; i <= bli_pkg::BAR_LEDS; i++) begin
            if ((bli_pkg::SEC_W+1)'(i) <= w_cnt) begin
                w_show_lamp[i] = 1'b1;
            end
        end
    end

    // timer and sequencer
    always_comb begin
        n_section  = r_section;
        n_known    = r_known;
        n_phase    = r_phase;
        n_delay    = r_delay;
        n_chase    = r_chase;
        n_lamp     = r_lamp;
        w_run_show = 1'b0;
        w_dec      = (r_delay != '0) ? r_delay - bli_pkg::DLY_W'(1) : '0;
        w_next_id  = {1'b0, r_chase} + (bli_pkg::CHASE_W+1)'(1);
        if (i_valid) begin
            if (i_cmd == bli_pkg::CMD_RESTART) begin
                n_lamp  = '0;
                n_phase = bli_pkg::PH_SHOW;
                n_delay = '0;
            end else begin
                n_delay = w_dec;
                if (w_dec == '0) begin
                    unique case (r_phase)
                        bli_pkg::PH_LOWBLINK: begin
                            n_lamp[0] = 1'b1;
                            n_phase   = bli_pkg::PH_SHOW;
                            n_delay   = bli_pkg::BLINK_ON_MS;
                        end
                        bli_pkg::PH_CHGSTART: begin
                            if (i_chg) begin
                                n_phase = bli_pkg::PH_CHGNEXT;
                                n_delay = bli_pkg::HALF_SEC_MS;
                            end else begin
                                w_run_show = 1'b1;
                            end
                        end
                        bli_pkg::PH_CHGNEXT: begin
                            for (int i = 1; i <= bli_pkg::BAR_LEDS; i++) begin
                                if (r_chase == bli_pkg::CHASE_W'(i)) begin
                                    n_lamp[i] = 1'b1;
                                end
                            end
                            if (i_chg && w_next_id <
                                (bli_pkg::CHASE_W+1)'(bli_pkg::BAR_LEDS + 1)) begin
                                n_chase = bli_pkg::CHASE_W'(w_next_id);
                                n_phase = bli_pkg::PH_CHGNEXT;
                            end else begin
                                n_phase = bli_pkg::PH_SHOW;
                            end
                            n_delay = bli_pkg::ONE_SEC_MS;
                        end
                        default: begin
                            w_run_show = 1'b1;
                        end
                    endcase
                    if (w_run_show) begin
                        n_section = w_pick;
                        n_known   = 1'b1;
                        n_lamp    = w_show_lamp;
                        n_phase   = w_show_phase;
                        n_delay   = w_show_delay;
                        n_chase   = w_show_chase;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= '0;
            r_known   <= 1'b0;
            r_phase   <= bli_pkg::PH_SHOW;
            r_delay   <= bli_pkg::HOLD_OFF_MS;
            r_chase   <= bli_pkg::CHASE_W'(1);
            r_lamp    <= '0;
        end else begin
            r_section <= n_section;
            r_known   <= n_known;
            r_phase   <= n_phase;
            r_delay   <= n_delay;
            r_chase   <= n_chase;
            r_lamp    <= n_lamp;
        end
    end

    assign o_res.red_on        = n_lamp[0];
    assign o_res.bar_mask      = n_lamp[bli_pkg::BAR_LEDS:1];
    assign o_res.level_section = n_section;

endmodule
`default_nettype wire

// ===== hw/rtl/battery_level_led_indicator.sv =====
// Each result is registered in the output stage before it appears on the master side.
// Throughput: one item per cycle while the skid entry is empty; state update is one combinational pass.
// A two-entry output stage (result register plus skid) keeps the input ready
// for one more item while a result waits on a stalled master side.
// Reset (synchronous, active low): config and state registers return to defaults, display
// state to the initial 200 ms wait, output stage empties.
`default_nettype none
module battery_level_led_indicator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire [bli_pkg::S_DATA_W-1:0]       i_s_tdata,   // battery_percent[6:0], charging[7], cut_off[8], zero pad
    input  wire                               i_s_tuser,   // cmd
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [bli_pkg::M_DATA_W-1:0]      o_m_tdata,   // red_on[0], bar_mask[3:1], level_section[6:4], zero pad
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [bli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [bli_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bli_pkg::t_cfg    r_cfg, n_cfg;
    bli_pkg::t_result w_res;
    bli_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;
    logic             w_s_fire, w_m_fire;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign w_m_fire    = r_out_valid && i_m_tready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            for (int j = 0; j < bli_pkg::NUM_BOUNDS; j++) begin
                if (i_cfg_index == bli_pkg::CFG_IDX_W'(j)) begin
                    n_cfg.bound[j] = i_cfg_data[bli_pkg::PCT_W-1:0];
                end
            end
            if (i_cfg_index == bli_pkg::CFG_MARGIN) begin
                n_cfg.margin = i_cfg_data[bli_pkg::MARGIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound  <= bli_pkg::BOUND_RESET;
            r_cfg.margin <= bli_pkg::MARGIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bli_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_fire),
        .i_cmd   (i_s_tuser),
        .i_pct   (i_s_tdata[bli_pkg::PCT_W-1:0]),
        .i_chg   (i_s_tdata[bli_pkg::PCT_W]),
        .i_cut   (i_s_tdata[bli_pkg::PCT_W+1]),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_s_fire) begin
                if (!r_out_valid || w_m_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_m_fire) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            if (!r_out_valid || w_m_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_m_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = bli_pkg::M_DATA_W'(r_out);

endmodule
`default_nettype wire

// ===== hw/rtl/bli_chk.sv =====
`default_nettype none
module bli_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_tvalid,
    input wire                               o_s_tready,
    input wire                               i_s_tuser,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [bli_pkg::M_DATA_W-1:0]       o_m_tdata
);

    // input may only back up behind a waiting result
    a_ready_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with nothing pending on the output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted transaction produced no result");

    a_section_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[6:4] <= 3'(bli_pkg::SECTIONS - 1))
        else $error("level section out of range");

    // a restart transaction leaves every LED dark
    a_restart_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser && !o_m_tvalid
        |=> o_m_tdata[3:0] == 4'd0)
        else $error("LEDs lit after restart");

endmodule

bind battery_level_led_indicator bli_chk u_bli_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
